>>> hw/rtl/ccv_pkg.sv
// Shared types and constants of the colour space converter.
// Holds the fixed-point format, function codes and pipeline side-band struct.
// No dependencies; every other file of the block imports it.
package ccv_pkg;

  localparam int FRAC_BITS  = 12;
  localparam int COMP_W     = 13;
  localparam int NUM_W      = 2 * COMP_W - 1;
  localparam int LANES      = 3;
  localparam int DIV_STAGES = COMP_W;
  localparam int PRE_STAGES = 3;
  localparam int N_STAGES   = PRE_STAGES + DIV_STAGES + 1;
  localparam int DATA_BITS  = 4 * COMP_W;
  localparam int TDATA_W    = ((DATA_BITS + 7) / 8) * 8;

  typedef logic [COMP_W-1:0] comp_t;
  typedef logic [NUM_W-1:0]  num_t;

  localparam comp_t ONE       = comp_t'(2 ** FRAC_BITS);
  localparam comp_t HUE_SIXTH = comp_t'(960);
  localparam comp_t HUE_THIRD = comp_t'(2 * 960);
  localparam comp_t HUE_2_3   = comp_t'(4 * 960);
  localparam comp_t HUE_FULL  = comp_t'(5760);

  typedef enum logic [1:0] {
    FUNC_RGB2HSV  = 2'd0,
    FUNC_HSV2RGB  = 2'd1,
    FUNC_RGB2CMYK = 2'd2,
    FUNC_CMYK2RGB = 2'd3
  } func_e;

  // Which component holds the maximum in RGB to HSV.
  typedef enum logic [1:0] {
    MAX_RED   = 2'd0,
    MAX_GREEN = 2'd1,
    MAX_BLUE  = 2'd2
  } max_sel_e;

  // Hue sextants, named by the colours at their ends.
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } hsv_sec_e;

  typedef struct packed {
    func_e    func;
    logic     err;
    logic     neg;
    logic     zmx;
    logic     zdl;
    comp_t    base;
    comp_t    sv;
    comp_t    cv;
    hsv_sec_e sec;
  } side_t;

endpackage

>>> hw/rtl/colour_space_converter_top.sv
// Colour space converter top level: RGB/HSV/CMYK conversion pipeline.
// Depends on ccv_pkg and ccv_div (the pipelined divider).
//
//   Channel   Direction  tdata (low bit up)              tuser
//   s_axis    in         comp_a, comp_b, comp_c, comp_d  func
//   m_axis    out        out_a, out_b, out_c, out_d      range_error
//
// One beat is accepted per cycle while the pipeline is not stalled; each beat yields exactly one result beat.
// The pipeline has three setup stages (range check and max/min,
// multipliers, numerator forming), 13 divider stages that each settle one
// quotient bit, and the output register.
// Every stage has its own valid bit and moves when it is empty or its
// successor moves, so bubbles are squeezed out during an output stall.
// Reset clears only the valid bits; the pipeline is empty afterwards.
module colour_space_converter_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // comp_a [12:0], comp_b [25:13], comp_c [38:26], comp_d [51:39], zeros
  input  logic [ccv_pkg::TDATA_W-1:0]  s_axis_tdata,
  // func [1:0]
  input  logic [1:0]                   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // out_a [12:0], out_b [25:13], out_c [38:26], out_d [51:39], zeros
  output logic [ccv_pkg::TDATA_W-1:0]  m_axis_tdata,
  // range_error [0]
  output logic [0:0]                   m_axis_tuser
);
  import ccv_pkg::*;

  // Stall chain: a stage may load when it is empty or its contents move on.
  logic [N_STAGES-1:0] vld_q;
  logic [N_STAGES-1:0] stage_en;

  assign stage_en[N_STAGES-1] = !vld_q[N_STAGES-1] || m_axis_tready;
  for (genvar k = 0; k < N_STAGES - 1; k++) begin : g_en
    assign stage_en[k] = !vld_q[k] || stage_en[k+1];
  end

  assign s_axis_tready = stage_en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < N_STAGES; k++) begin
        if (stage_en[k]) begin
          vld_q[k] <= (k == 0) ? s_axis_tvalid : vld_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: unpack, range check, maximum and minimum of the components.
  // ---------------------------------------------------------------------
  func_e    func_in;
  comp_t    a_in, b_in, c_in, d_in;
  logic     err_in;
  comp_t    mx_in, mn_in;
  max_sel_e msel_in;

  assign func_in = func_e'(s_axis_tuser);
  assign a_in    = s_axis_tdata[COMP_W-1:0];
  assign b_in    = s_axis_tdata[2*COMP_W-1:COMP_W];
  assign c_in    = s_axis_tdata[3*COMP_W-1:2*COMP_W];
  assign d_in    = s_axis_tdata[4*COMP_W-1:3*COMP_W];

  always_comb begin
    unique case (func_in)
      FUNC_HSV2RGB:  err_in = (a_in > HUE_FULL) || (b_in > ONE) || (c_in > ONE);
      FUNC_CMYK2RGB: err_in = (a_in > ONE) || (b_in > ONE) || (c_in > ONE) ||
                              (d_in > ONE);
      default:       err_in = (a_in > ONE) || (b_in > ONE) || (c_in > ONE);
    endcase
  end

  always_comb begin
    mx_in = a_in;
    mn_in = a_in;
    if (b_in > mx_in) mx_in = b_in;
    if (c_in > mx_in) mx_in = c_in;
    if (b_in < mn_in) mn_in = b_in;
    if (c_in < mn_in) mn_in = c_in;
    if (a_in == mx_in) begin
      msel_in = MAX_RED;
    end else if (b_in == mx_in) begin
      msel_in = MAX_GREEN;
    end else begin
      msel_in = MAX_BLUE;
    end
  end

  func_e    func1_q;
  logic     err1_q;
  comp_t    a1_q, b1_q, c1_q, d1_q, mx1_q, mn1_q;
  max_sel_e msel1_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      func1_q <= func_in;
      err1_q  <= err_in;
      a1_q    <= a_in;
      b1_q    <= b_in;
      c1_q    <= c_in;
      d1_q    <= d_in;
      mx1_q   <= mx_in;
      mn1_q   <= mn_in;
      msel1_q <= msel_in;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: one 13 x 13 multiplier per lane, operands chosen by func.
  // ---------------------------------------------------------------------
  comp_t    dl, dx, dy, mag, base, hf, t_d;
  logic     neg;
  hsv_sec_e sec_d;
  comp_t    mul_x [LANES];
  comp_t    mul_y [LANES];
  comp_t    den2_d [LANES];
  num_t     p2_d [LANES];
  side_t    side2_d;

  always_comb begin
    dl = mx1_q - mn1_q;
    unique case (msel1_q)
      MAX_RED: begin
        dx = b1_q; dy = c1_q; base = '0;
      end
      MAX_GREEN: begin
        dx = c1_q; dy = a1_q; base = HUE_THIRD;
      end
      default: begin
        dx = a1_q; dy = b1_q; base = HUE_2_3;
      end
    endcase
    neg = (dy > dx);
    mag = neg ? (dy - dx) : (dx - dy);

    // Hue position within a pair of sextants, and the sextant itself.
    if (a1_q >= HUE_FULL) begin
      hf = '0;
    end else if (a1_q >= HUE_2_3) begin
      hf = a1_q - HUE_2_3;
    end else if (a1_q >= HUE_THIRD) begin
      hf = a1_q - HUE_THIRD;
    end else begin
      hf = a1_q;
    end
    t_d = (hf >= HUE_SIXTH) ? (hf - HUE_SIXTH) : (HUE_SIXTH - hf);
    if (a1_q < HUE_SIXTH) begin
      sec_d = SEC_RY;
    end else if (a1_q < HUE_THIRD) begin
      sec_d = SEC_YG;
    end else if (a1_q < comp_t'(3 * 960)) begin
      sec_d = SEC_GC;
    end else if (a1_q < HUE_2_3) begin
      sec_d = SEC_CB;
    end else if (a1_q < comp_t'(5 * 960)) begin
      sec_d = SEC_BM;
    end else begin
      sec_d = SEC_MR;
    end

    for (int l = 0; l < LANES; l++) begin
      mul_x[l]  = '0;
      mul_y[l]  = '0;
      den2_d[l] = comp_t'(1);
    end
    side2_d      = '0;
    side2_d.func = func1_q;
    side2_d.err  = err1_q;
    side2_d.neg  = neg;
    side2_d.zmx  = (mx1_q == '0);
    side2_d.zdl  = (dl == '0);
    side2_d.base = base;
    side2_d.sec  = sec_d;

    unique case (func1_q)
      FUNC_RGB2HSV: begin
        mul_x[0] = dl;  mul_y[0] = comp_t'(1); den2_d[0] = mx1_q;
        mul_x[1] = mag; mul_y[1] = HUE_SIXTH;  den2_d[1] = dl;
        side2_d.sv = mx1_q;
      end
      FUNC_HSV2RGB: begin
        mul_x[0] = c1_q; mul_y[0] = b1_q; den2_d[0] = HUE_SIXTH;
        side2_d.sv = c1_q;
      end
      FUNC_RGB2CMYK: begin
        mul_x[0] = mx1_q - a1_q; mul_y[0] = comp_t'(1); den2_d[0] = mx1_q;
        mul_x[1] = mx1_q - b1_q; mul_y[1] = comp_t'(1); den2_d[1] = mx1_q;
        mul_x[2] = mx1_q - c1_q; mul_y[2] = comp_t'(1); den2_d[2] = mx1_q;
        side2_d.sv = ONE - mx1_q;
      end
      default: begin
        mul_x[0] = ONE - a1_q; mul_y[0] = ONE - d1_q;
        mul_x[1] = ONE - b1_q; mul_y[1] = ONE - d1_q;
        mul_x[2] = ONE - c1_q; mul_y[2] = ONE - d1_q;
      end
    endcase

    for (int l = 0; l < LANES; l++) begin
      p2_d[l] = num_t'(mul_x[l]) * num_t'(mul_y[l]);
    end
  end

  num_t  p2_q   [LANES];
  comp_t den2_q [LANES];
  comp_t t2_q;
  side_t side2_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[1]) begin
      for (int l = 0; l < LANES; l++) begin
        p2_q[l]   <= p2_d[l];
        den2_q[l] <= den2_d[l];
      end
      t2_q    <= t_d;
      side2_q <= side2_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: dividends. HSV to RGB forms C * (960 - t) with a multiplier
  // of its own here, which the divider then divides by 960.
  // CMYK to RGB divides by one, so the divider just passes its products.
  // ---------------------------------------------------------------------
  comp_t                chroma;
  num_t  [LANES-1:0]    num3_d;
  side_t                side3_d;

  always_comb begin
    chroma  = comp_t'(p2_q[0] >> FRAC_BITS);
    side3_d = side2_q;
    side3_d.cv = chroma;
    unique case (side2_q.func)
      FUNC_RGB2HSV: begin
        num3_d[0] = p2_q[0] << FRAC_BITS;
        num3_d[1] = p2_q[1];
        num3_d[2] = '0;
      end
      FUNC_HSV2RGB: begin
        num3_d[0] = num_t'(chroma) * num_t'(HUE_SIXTH - t2_q);
        num3_d[1] = '0;
        num3_d[2] = '0;
      end
      FUNC_RGB2CMYK: begin
        for (int l = 0; l < LANES; l++) begin
          num3_d[l] = p2_q[l] << FRAC_BITS;
        end
      end
      default: begin
        for (int l = 0; l < LANES; l++) begin
          num3_d[l] = p2_q[l] >> FRAC_BITS;
        end
      end
    endcase
  end

  num_t  [LANES-1:0] num3_q;
  comp_t [LANES-1:0] den3_q;
  side_t             side3_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[2]) begin
      num3_q  <= num3_d;
      side3_q <= side3_d;
      for (int l = 0; l < LANES; l++) begin
        den3_q[l] <= den2_q[l];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Divider stages; the side-band fields travel alongside in step.
  // ---------------------------------------------------------------------
  comp_t [LANES-1:0] quo;
  side_t             side_q [DIV_STAGES];

  ccv_div u_div (
    .clk_i (clk_i),
    .en_i  (stage_en[PRE_STAGES +: DIV_STAGES]),
    .num_i (num3_q),
    .den_i (den3_q),
    .quo_o (quo)
  );

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (stage_en[PRE_STAGES + s]) begin
        side_q[s] <= (s == 0) ? side3_q : side_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Final stage: assemble the result and apply the special cases.
  // ---------------------------------------------------------------------
  side_t sd;
  comp_t hue, mval, xv, rr, gg, bb;
  comp_t oa_d, ob_d, oc_d, od_d;

  always_comb begin
    sd   = side_q[DIV_STAGES-1];
    oa_d = '0;
    ob_d = '0;
    oc_d = '0;
    od_d = '0;
    rr   = '0;
    gg   = '0;
    bb   = '0;
    xv   = quo[0];
    mval = sd.sv - sd.cv;

    // Hue truncates toward zero; a negative result wraps by a full circle.
    if (!sd.neg) begin
      hue = sd.base + quo[1];
    end else if (quo[1] > sd.base) begin
      hue = sd.base + HUE_FULL - quo[1];
    end else begin
      hue = sd.base - quo[1];
    end

    unique case (sd.sec)
      SEC_RY:  begin rr = sd.cv; gg = xv;    end
      SEC_YG:  begin rr = xv;    gg = sd.cv; end
      SEC_GC:  begin gg = sd.cv; bb = xv;    end
      SEC_CB:  begin gg = xv;    bb = sd.cv; end
      SEC_BM:  begin rr = xv;    bb = sd.cv; end
      default: begin rr = sd.cv; bb = xv;    end
    endcase

    unique case (sd.func)
      FUNC_RGB2HSV: begin
        oa_d = sd.zdl ? '0 : hue;
        ob_d = sd.zmx ? '0 : quo[0];
        oc_d = sd.sv;
      end
      FUNC_HSV2RGB: begin
        oa_d = rr + mval;
        ob_d = gg + mval;
        oc_d = bb + mval;
      end
      FUNC_RGB2CMYK: begin
        oa_d = sd.zmx ? '0 : quo[0];
        ob_d = sd.zmx ? '0 : quo[1];
        oc_d = sd.zmx ? '0 : quo[2];
        od_d = sd.sv;
      end
      default: begin
        oa_d = quo[0];
        ob_d = quo[1];
        oc_d = quo[2];
      end
    endcase

    if (sd.err) begin
      oa_d = '0;
      ob_d = '0;
      oc_d = '0;
      od_d = '0;
    end
  end

  comp_t oa_q, ob_q, oc_q, od_q;
  logic  oerr_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[N_STAGES-1]) begin
      oa_q   <= oa_d;
      ob_q   <= ob_d;
      oc_q   <= oc_d;
      od_q   <= od_d;
      oerr_q <= sd.err;
    end
  end

  assign m_axis_tvalid = vld_q[N_STAGES-1];
  assign m_axis_tdata  = {{(TDATA_W - DATA_BITS){1'b0}}, od_q, oc_q, ob_q, oa_q};
  assign m_axis_tuser  = oerr_q;

endmodule

>>> hw/rtl/ccv_div.sv
// Pipelined restoring divider, three lanes, one quotient bit per stage.
// Depends on ccv_pkg; stage enables come from the top level's stall chain.
module ccv_div (
  input  logic                                    clk_i,
  input  logic         [ccv_pkg::DIV_STAGES-1:0]  en_i,
  input  ccv_pkg::num_t  [ccv_pkg::LANES-1:0]     num_i,
  input  ccv_pkg::comp_t [ccv_pkg::LANES-1:0]     den_i,
  output ccv_pkg::comp_t [ccv_pkg::LANES-1:0]     quo_o
);
  import ccv_pkg::*;

  num_t  rem_q [DIV_STAGES][LANES];
  comp_t den_q [DIV_STAGES][LANES];
  comp_t quo_q [DIV_STAGES][LANES];

  num_t  rem_in [DIV_STAGES][LANES];
  comp_t den_in [DIV_STAGES][LANES];
  comp_t quo_in [DIV_STAGES][LANES];
  num_t  rem_d  [DIV_STAGES][LANES];
  comp_t quo_d  [DIV_STAGES][LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem_in[0][l] = num_i[l];
      den_in[0][l] = den_i[l];
      quo_in[0][l] = '0;
    end
    for (int s = 1; s < DIV_STAGES; s++) begin
      for (int l = 0; l < LANES; l++) begin
        rem_in[s][l] = rem_q[s-1][l];
        den_in[s][l] = den_q[s-1][l];
        quo_in[s][l] = quo_q[s-1][l];
      end
    end
  end

  // Stage s decides quotient bit COMP_W-1-s against the shifted divisor.
  always_comb begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      for (int l = 0; l < LANES; l++) begin
        num_t shd;
        logic fits;
        shd  = num_t'(den_in[s][l]) << (COMP_W - 1 - s);
        fits = (rem_in[s][l] >= shd);
        rem_d[s][l] = fits ? (rem_in[s][l] - shd) : rem_in[s][l];
        quo_d[s][l] = {quo_in[s][l][COMP_W-2:0], fits};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (en_i[s]) begin
        for (int l = 0; l < LANES; l++) begin
          rem_q[s][l] <= rem_d[s][l];
          den_q[s][l] <= den_in[s][l];
          quo_q[s][l] <= quo_d[s][l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo_o[l] = quo_q[DIV_STAGES-1][l];
    end
  end

endmodule

>>> hw/rtl/ccv_checker.sv
// Port-level checks for the colour space converter and their bind.
// Depends on ccv_pkg; attaches to colour_space_converter_top.
module ccv_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [ccv_pkg::TDATA_W-1:0]  s_axis_tdata,
  input logic [1:0]                   s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [ccv_pkg::TDATA_W-1:0]  m_axis_tdata,
  input logic [0:0]                   m_axis_tuser
);
  import ccv_pkg::*;

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // A range error zeroes every component.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("range error with nonzero components");

  // Results stay within their ranges.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[COMP_W-1:0] < HUE_FULL) &&
      (m_axis_tdata[2*COMP_W-1:COMP_W] <= ONE) &&
      (m_axis_tdata[3*COMP_W-1:2*COMP_W] <= ONE) &&
      (m_axis_tdata[4*COMP_W-1:3*COMP_W] <= ONE))
    else $error("result component out of range");

  // A clock edge under reset leaves the pipeline empty, so nothing comes out next.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result beat during reset");

endmodule

bind colour_space_converter_top ccv_checker u_ccv_checker (.*);

>>> test/tb.sv
// Self-checking testbench of the colour space converter top level.
// Depends on ccv_pkg and colour_space_converter_top; directed and random beats.
// A local converter model predicts each result beat, and the monitor checks it.
`timescale 1ns / 100ps

module tb;
  import ccv_pkg::*;

  typedef struct packed {
    func_e func;
    comp_t a;
    comp_t b;
    comp_t c;
    comp_t d;
  } pixel_t;

  typedef struct packed {
    comp_t a;
    comp_t b;
    comp_t c;
    comp_t d;
    logic  err;
  } colour_t;

  localparam int LIMIT = 200000;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;
  logic [1:0]         s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic [0:0]         m_axis_tuser;

  pixel_t  pending_pixels[$];
  colour_t expected_colours[$];
  int      mismatches;
  int      cycles;
  int      burst_left;
  int      gap_left;
  int      stall_phase;

  colour_space_converter_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Computes the converted colour in wide integers; truncation matches the block.
  function automatic colour_t convert_colour(pixel_t p);
    colour_t   res;
    longint    one, r, g, bl, mx, mn, dl, h, cc, f, t, x, m, sec, kk;
    longint    ra, rb, rc, rd;
    bit        err;
    one = longint'(ONE);
    ra = 0; rb = 0; rc = 0; rd = 0;
    r = p.a; g = p.b; bl = p.c;
    case (p.func)
      FUNC_HSV2RGB:  err = (r > 5760) || (g > one) || (bl > one);
      FUNC_CMYK2RGB: err = (r > one) || (g > one) || (bl > one) || (p.d > one);
      default:       err = (r > one) || (g > one) || (bl > one);
    endcase
    if (!err) begin
      case (p.func)
        FUNC_RGB2HSV: begin
          mx = r; mn = r;
          if (g > mx) mx = g;
          if (bl > mx) mx = bl;
          if (g < mn) mn = g;
          if (bl < mn) mn = bl;
          dl = mx - mn;
          rc = mx;
          rb = (mx != 0) ? dl * one / mx : 0;
          if (dl != 0) begin
            // Signed division truncates toward zero, as in C.
            if (r == mx) h = (960 * (g - bl)) / dl;
            else if (g == mx) h = 1920 + (960 * (bl - r)) / dl;
            else h = 3840 + (960 * (r - g)) / dl;
            if (h < 0) h += 5760;
            ra = h;
          end
        end
        FUNC_HSV2RGB: begin
          cc = (bl * g) >> FRAC_BITS;
          f = r % 1920;
          t = (f >= 960) ? f - 960 : 960 - f;
          x = cc * (960 - t) / 960;
          m = bl - cc;
          sec = r / 960;
          if (sec > 5) sec = 5;
          case (sec)
            0: begin ra = cc; rb = x; end
            1: begin ra = x; rb = cc; end
            2: begin rb = cc; rc = x; end
            3: begin rb = x; rc = cc; end
            4: begin ra = x; rc = cc; end
            default: begin ra = cc; rc = x; end
          endcase
          ra += m; rb += m; rc += m;
        end
        FUNC_RGB2CMYK: begin
          mx = r;
          if (g > mx) mx = g;
          if (bl > mx) mx = bl;
          rd = one - mx;
          if (mx != 0) begin
            ra = (mx - r) * one / mx;
            rb = (mx - g) * one / mx;
            rc = (mx - bl) * one / mx;
          end
        end
        default: begin
          kk = one - p.d;
          ra = ((one - r) * kk) >> FRAC_BITS;
          rb = ((one - g) * kk) >> FRAC_BITS;
          rc = ((one - bl) * kk) >> FRAC_BITS;
        end
      endcase
    end
    res.a = comp_t'(ra);
    res.b = comp_t'(rb);
    res.c = comp_t'(rc);
    res.d = comp_t'(rd);
    res.err = err;
    return res;
  endfunction

  task automatic add_pixel(func_e fn, int a, int b, int c, int d);
    pixel_t p;
    p.func = fn;
    p.a = comp_t'(a);
    p.b = comp_t'(b);
    p.c = comp_t'(c);
    p.d = comp_t'(d);
    pending_pixels.push_back(p);
  endtask

  // Picks a component: mostly in range, with the top value, one past it, zero and wild values mixed in.
  function automatic int pick_comp(int top);
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 0;
    if (sel == 1) return top;
    if (sel == 2) return $urandom_range(0, 8191);
    if (sel == 3) return top + 1;
    return $urandom_range(0, top);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  initial begin
    func_e fn;
    int    top;
    mismatches = 0;
    rst_ni = 1'b0;
    // Directed part: extremes, every function, grey, black, full hue, range errors.
    add_pixel(FUNC_RGB2HSV, 0, 0, 0, 0);
    add_pixel(FUNC_RGB2HSV, 4096, 4096, 4096, 0);
    add_pixel(FUNC_RGB2HSV, 4096, 0, 0, 0);
    add_pixel(FUNC_RGB2HSV, 0, 4096, 100, 0);
    add_pixel(FUNC_RGB2HSV, 50, 0, 4096, 0);
    add_pixel(FUNC_RGB2HSV, 4096, 0, 4095, 8191);
    add_pixel(FUNC_RGB2HSV, 4097, 0, 0, 0);
    add_pixel(FUNC_HSV2RGB, 5760, 4096, 4096, 0);
    add_pixel(FUNC_HSV2RGB, 5759, 4096, 4096, 0);
    add_pixel(FUNC_HSV2RGB, 0, 0, 4096, 0);
    add_pixel(FUNC_HSV2RGB, 960, 4096, 2000, 0);
    add_pixel(FUNC_HSV2RGB, 5761, 0, 0, 0);
    add_pixel(FUNC_HSV2RGB, 100, 8191, 0, 0);
    add_pixel(FUNC_RGB2CMYK, 0, 0, 0, 0);
    add_pixel(FUNC_RGB2CMYK, 4096, 2048, 1, 0);
    add_pixel(FUNC_RGB2CMYK, 0, 0, 8191, 0);
    add_pixel(FUNC_CMYK2RGB, 0, 0, 0, 0);
    add_pixel(FUNC_CMYK2RGB, 4096, 4096, 4096, 4096);
    add_pixel(FUNC_CMYK2RGB, 100, 200, 300, 4097);
    add_pixel(FUNC_CMYK2RGB, 8191, 8191, 8191, 8191);
    add_pixel(FUNC_CMYK2RGB, 1000, 2000, 3000, 500);
    for (int i = 0; i < 500; i++) begin
      fn = func_e'($urandom_range(0, 3));
      top = (fn == FUNC_HSV2RGB) ? 5760 : 4096;
      add_pixel(fn, pick_comp(top), pick_comp(4096), pick_comp(4096),
                (fn == FUNC_CMYK2RGB) ? pick_comp(4096) : $urandom_range(0, 8191));
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: bursts of beats separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t p;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        expected_colours.push_back(convert_colour(pending_pixels.pop_front()));
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        p = pending_pixels[0];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'({p.d, p.c, p.b, p.a});
        s_axis_tuser  <= p.func;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: free-running stretches alternate with random stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_phase   <= 0;
    end else begin
      stall_phase <= (stall_phase + 1) % 256;
      if (stall_phase < 64) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 2) != 0);
    end
  end

  // Monitor: checks each accepted result beat against the oldest prediction.
  always @(posedge clk_i) begin
    colour_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_colours.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = expected_colours.pop_front();
        if (m_axis_tdata[12:0] !== want.a) report_mismatch("out_a", m_axis_tdata[12:0], want.a);
        if (m_axis_tdata[25:13] !== want.b)
          report_mismatch("out_b", m_axis_tdata[25:13], want.b);
        if (m_axis_tdata[38:26] !== want.c)
          report_mismatch("out_c", m_axis_tdata[38:26], want.c);
        if (m_axis_tdata[51:39] !== want.d)
          report_mismatch("out_d", m_axis_tdata[51:39], want.d);
        if (m_axis_tuser[0] !== want.err)
          report_mismatch("range_error", m_axis_tuser[0], want.err);
      end
    end
  end

  // End of run: all beats sent and checked, then a final quiet wait before the verdict.
  initial begin
    cycles = 0;
    wait (rst_ni === 1'b1);
    while (cycles < LIMIT && (pending_pixels.size() != 0 || s_axis_tvalid ||
                              expected_colours.size() != 0)) begin
      @(posedge clk_i);
      cycles++;
    end
    if (cycles >= LIMIT) begin
      $display("tb NOT OK");
    end else begin
      repeat (40) @(posedge clk_i);
      if (mismatches == 0 && expected_colours.size() == 0) begin
        $display("tb OK");
      end else begin
        $display("tb NOT OK");
      end
    end
    $finish;
  end

endmodule

>>> colour_space_converter_top.f
hw/rtl/ccv_pkg.sv
hw/rtl/ccv_div.sv
hw/rtl/colour_space_converter_top.sv
hw/rtl/ccv_checker.sv
test/tb.sv
